FILE: rtl/plsq_pkg.sv
package plsq_pkg;

	localparam int unsigned MV_W      = 13;
	localparam int unsigned CNT_W     = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 16;
	localparam int unsigned IN_W      = 16;
	localparam int unsigned OUT_W     = 24;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SEAL = 2'd1,
		PH_FIRE = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRESSURE_REF  = 3'd0,
		REG_PRESSURE_TOL  = 3'd1,
		REG_BOTTLE_TIMEOUT = 3'd2,
		REG_SEAL_HOLD     = 3'd3,
		REG_FIRE_HOLD     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [MV_W-1:0]  pressure_ref_mv;
		logic [MV_W-1:0]  pressure_tolerance_mv;
		logic [CNT_W-1:0] bottle_timeout_ticks;
		logic [CNT_W-1:0] seal_hold_ticks;
		logic [CNT_W-1:0] fire_hold_ticks;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		pressure_ref_mv:       13'd2000,
		pressure_tolerance_mv: 13'd3000,
		bottle_timeout_ticks:  16'd1000,
		seal_hold_ticks:       16'd300,
		fire_hold_ticks:       16'd500
	};

	typedef struct packed {
		logic            fire_command;
		logic            power_on;
		logic [MV_W-1:0] pressure_feedback_mv;
		logic            round_present;
	} item_t;

	typedef struct packed {
		logic [MV_W-1:0] dac_setpoint_mv;
		phase_t          phase;
		logic            clearing_pending;
		logic            bottle_ok;
		logic            pressure_ok;
		logic            feed_request;
		logic            shot_in_progress;
		logic            fire_valve_open;
		logic            seal_valve_open;
	} result_t;

	typedef struct packed {
		phase_t           phase;
		logic [CNT_W-1:0] seal_cnt;
		logic [CNT_W-1:0] fire_cnt;
		logic [CNT_W-1:0] wait_cnt;
		logic             first_shot_done;
		logic             fire_pending;
		logic             seal_open;
		logic             fire_open;
		logic             pressure_ok;
		logic             bottle_ok;
		logic             shot_active;
		logic             feed_req;
	} seq_state_t;

	localparam seq_state_t STATE_RESET = '{
		phase:           PH_IDLE,
		seal_cnt:        '0,
		fire_cnt:        '0,
		wait_cnt:        '0,
		first_shot_done: 1'b0,
		fire_pending:    1'b0,
		seal_open:       1'b0,
		fire_open:       1'b0,
		pressure_ok:     1'b0,
		bottle_ok:       1'b0,
		shot_active:     1'b0,
		feed_req:        1'b0
	};

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

FILE: rtl/plsq_cfg_regs.sv
module plsq_cfg_regs
	import plsq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DAT_W-1:0] wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				REG_PRESSURE_REF:   cfg_q.pressure_ref_mv       <= wr_data[MV_W-1:0];
				REG_PRESSURE_TOL:   cfg_q.pressure_tolerance_mv <= wr_data[MV_W-1:0];
				REG_BOTTLE_TIMEOUT: cfg_q.bottle_timeout_ticks  <= wr_data[CNT_W-1:0];
				REG_SEAL_HOLD:      cfg_q.seal_hold_ticks       <= wr_data[CNT_W-1:0];
				REG_FIRE_HOLD:      cfg_q.fire_hold_ticks       <= wr_data[CNT_W-1:0];
				// Indexes past the register list are dropped.
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/plsq_core.sv
module plsq_core
	import plsq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	seq_state_t st_q;
	seq_state_t nx;
	logic [MV_W-1:0] diff;
	logic            run;

	always_comb begin
		nx = st_q;
		if (item.fire_command) begin
			nx.fire_pending = 1'b1;
		end

		diff = (item.pressure_feedback_mv >= cfg.pressure_ref_mv)
			? item.pressure_feedback_mv - cfg.pressure_ref_mv
			: cfg.pressure_ref_mv - item.pressure_feedback_mv;

		if (diff < cfg.pressure_tolerance_mv) begin
			nx.pressure_ok = 1'b1;
			nx.bottle_ok   = 1'b1;
			nx.wait_cnt    = '0;
		end else begin
			nx.wait_cnt    = sat_inc(st_q.wait_cnt);
			nx.pressure_ok = 1'b0;
			// A bottle that cannot reach pressure in time halts the shot: bottle_ok clears and the phase returns to idle.
			if (nx.wait_cnt > cfg.bottle_timeout_ticks) begin
				nx.bottle_ok       = 1'b0;
				nx.first_shot_done = 1'b0;
				nx.phase           = PH_IDLE;
			end
		end

		run = nx.bottle_ok && nx.pressure_ok && item.power_on
			&& (nx.fire_pending || nx.phase != PH_IDLE);

		if (run) begin
			unique case (nx.phase)
				PH_IDLE: begin
					if (item.round_present || !nx.first_shot_done) begin
						nx.shot_active = 1'b1;
						nx.phase       = PH_SEAL;
						nx.feed_req    = 1'b0;
					end else begin
						nx.feed_req = 1'b1;
					end
				end
				PH_SEAL: begin
					nx.seal_cnt  = sat_inc(st_q.seal_cnt);
					nx.seal_open = 1'b1;
					if (nx.seal_cnt > cfg.seal_hold_ticks) begin
						nx.phase = PH_FIRE;
					end
				end
				PH_FIRE: begin
					nx.fire_cnt  = sat_inc(st_q.fire_cnt);
					nx.fire_open = 1'b1;
					if (nx.fire_cnt > cfg.fire_hold_ticks) begin
						nx.phase = PH_DONE;
					end
				end
				PH_DONE: begin
					nx.seal_cnt        = '0;
					nx.fire_cnt        = '0;
					nx.shot_active     = 1'b0;
					nx.fire_pending    = 1'b0;
					nx.phase           = PH_IDLE;
					nx.seal_open       = 1'b0;
					nx.fire_open       = 1'b0;
					nx.first_shot_done = 1'b1;
				end
				default: ;
			endcase
		end

		if (!item.power_on) begin
			nx = STATE_RESET;
		end

		result.seal_valve_open  = nx.seal_open;
		result.fire_valve_open  = nx.fire_open;
		result.shot_in_progress = nx.shot_active;
		result.feed_request     = nx.feed_req;
		result.pressure_ok      = nx.pressure_ok;
		result.bottle_ok        = nx.bottle_ok;
		result.clearing_pending = !nx.first_shot_done;
		result.phase            = nx.phase;
		result.dac_setpoint_mv  = cfg.pressure_ref_mv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (step) begin
			st_q <= nx;
		end
	end

`ifndef SYNTH
	// The fire valve only opens after a seal hold has opened the seal valve.
	a_fire_needs_seal: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.fire_open |-> st_q.seal_open)
		else $error("fire valve open without seal valve");

	// Any phase past idle belongs to a shot in progress.
	a_phase_in_shot: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase != PH_IDLE) |-> st_q.shot_active)
		else $error("sequence phase active without a shot in progress");

	// State moves only when a word is handed on to the result register.
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(st_q))
		else $error("sequencer state changed without a step");
`endif

endmodule

FILE: rtl/pneumatic_launch_sequencer.sv
// Pneumatic launch sequencer. Each input word is one control tick and yields
// exactly one result word. The block takes one word per clock while results
// are taken: a word is held in an input register, evaluated against the
// sequencer state by one pass of compare and counter logic, and lands in the
// result register, which drives m_tvalid; a result that waits to be taken
// stalls that hand-on. With m_tready held high, a word accepted in every cycle
// leaves in every cycle. The input register lets one further word be accepted
// while a result waits to be taken. Configuration registers (index 0 pressure
// reference, 1 tolerance, 2 bottle timeout, 3 seal hold, 4 fire hold) are
// written through the cfg channel, which is always ready; write them only
// while no words are in flight. Indexes beyond 4 are ignored.
module pneumatic_launch_sequencer
	import plsq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// round_present, pressure_feedback_mv[12:0], power_on, fire_command
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// seal_valve_open, fire_valve_open, shot_in_progress, feed_request,
	// pressure_ok, bottle_ok, clearing_pending, phase[1:0],
	// dac_setpoint_mv[12:0], zero padding
	output logic [OUT_W-1:0]     m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int unsigned RES_W = $bits(result_t);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t result_q;
	logic    out_valid_q;
	logic    advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;

	plsq_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_t'(s_tdata);
		end
	end

	plsq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W-RES_W){1'b0}}, result_q};

`ifndef SYNTH
	// A word in the input register stays put until it is handed on.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost a word");

	// A waiting result is never overwritten by the next tick.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !advance)
		else $error("result register overwritten while stalled");

	// An offered result word stays on the bus until it is taken.
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result word changed while stalled");
`endif

endmodule
